FILE: hw/rtl/tcw_pkg.sv
// Shared constants and codes for the text console writer.
package tcw_pkg;

  // Default screen geometry
  localparam int unsigned ColumnsDef = 80;
  localparam int unsigned RowsDef    = 25;

  // Fixed field widths
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CharW  = 8;
  localparam int unsigned IndexW = 11;
  localparam int unsigned PosW   = 11;
  localparam int unsigned AttrW  = 8;
  localparam int unsigned CellW  = 16;

  // Input modes
  localparam logic [ModeW-1:0] ModePut   = 2'd0;
  localparam logic [ModeW-1:0] ModeClear = 2'd1;
  localparam logic [ModeW-1:0] ModeRead  = 2'd2;
  localparam logic [ModeW-1:0] ModeNop   = 2'd3;

  // Control characters and blank
  localparam logic [CharW-1:0] ChNewline   = 8'h0A;
  localparam logic [CharW-1:0] ChBackspace = 8'h08;
  localparam logic [CharW-1:0] ChReturn    = 8'h0D;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;

  // Attribute after reset
  localparam logic [AttrW-1:0] ResetAttr = 8'h0A;

  // APB register map
  localparam int unsigned      ApbAddrW    = 3;
  localparam int unsigned      ApbDataW    = 32;
  localparam logic [ApbAddrW-1:0] RegAttrAddr = 3'd0;

endpackage

FILE: hw/rtl/tcw_mem.sv
// Screen store: single write port, one registered read port.
module tcw_mem #(
  parameter int unsigned Depth = 2000,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tcw_apb.sv
// APB register block holding the text attribute.
module tcw_apb import tcw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [AttrW-1:0]    attr_o
);

  logic [AttrW-1:0] attr_q, attr_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == RegAttrAddr);

  // attribute register
  always_comb begin
    attr_d = attr_q;
    if (wr_en) begin
      attr_d = pwdata[AttrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ResetAttr;
    end else begin
      attr_q <= attr_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == RegAttrAddr) begin
      prdata = ApbDataW'(attr_q);
    end
  end

  assign attr_o = attr_q;

endmodule

FILE: hw/rtl/text_console_writer.sv
// Text console writer top level: cursor control, sweep sequencer, output register.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | mode_i, char_code_i, cell_index_i
//   out     | output    | out_valid_o/out_ready_i | cursor_position_o, cell_value_o, scrolled_o
//   cfg     | input     | APB psel/penable      | paddr, pwdata, prdata
//
// Plain characters, returns, newlines and backspaces without scroll finish in the idle state.
// Read: waits in StRdWait for the registered screen store read port.
// Clear blanks every cell; scroll copies each row up and blanks the last row, one cell
// a cycle through the single store write port.
// After reset the store is blanked before the first input.
// A new input is taken while the previous result is taken in the same cycle.
module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = ColumnsDef,
  parameter int unsigned ROWS    = RowsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input transactions
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ModeW-1:0]    mode_i,
  input  logic [CharW-1:0]    char_code_i,
  input  logic [IndexW-1:0]   cell_index_i,
  // result transactions
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PosW-1:0]     cursor_position_o,
  output logic [CellW-1:0]    cell_value_o,
  output logic                scrolled_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned Cells = COLUMNS * ROWS;
  localparam int unsigned AdrW  = $clog2(Cells);
  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned WideW = (AdrW > IndexW) ? AdrW : IndexW;

  localparam logic [2:0] StInit   = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StRdWait = 3'd2;
  localparam logic [2:0] StCopy   = 3'd3;
  localparam logic [2:0] StDrain  = 3'd4;
  localparam logic [2:0] StFill   = 3'd5;

  localparam logic [AdrW-1:0] LastCell = AdrW'(Cells - 1);
  localparam logic [AdrW-1:0] Cols     = AdrW'(COLUMNS);
  localparam logic [AdrW-1:0] LastRow0 = AdrW'(Cells - COLUMNS);

  logic [2:0]        state_q, state_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [AdrW-1:0]   cnt_q, cnt_d;
  logic              cp_vld_q, cp_vld_d;
  logic [AdrW-1:0]   cp_dst_q, cp_dst_d;
  logic              scr_q, scr_d;
  logic              rd_ok_q, rd_ok_d;
  logic              out_vld_q, out_vld_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [CellW-1:0]  val_q, val_d;
  logic              oscr_q, oscr_d;

  logic [AttrW-1:0]  attr;
  logic              mem_we;
  logic [AdrW-1:0]   mem_waddr, mem_raddr;
  logic [CellW-1:0]  mem_wdata, mem_rdata;
  logic [CellW-1:0]  blank;
  logic              accept;
  logic              done;
  logic [AdrW-1:0]   row_base;
  logic [ColW:0]     col_n;
  logic [RowW:0]     row_n;
  logic [WideW-1:0]  idx_w;
  logic [WideW-1:0]  pos_w;

  // configuration registers
  tcw_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr_o  (attr)
  );

  // screen store
  tcw_mem #(
    .Depth (Cells),
    .Width (CellW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign blank      = {attr, ChSpace};
  assign in_ready_o = (state_q == StIdle) && (!out_vld_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign row_base   = AdrW'(row_q) * Cols;
  assign idx_w      = WideW'(cell_index_i);

  // sequencer, cursor update and store access
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    cnt_d     = cnt_q;
    cp_vld_d  = 1'b0;
    cp_dst_d  = cp_dst_q;
    scr_d     = scr_q;
    rd_ok_d   = rd_ok_q;
    val_d     = val_q;
    oscr_d    = oscr_q;
    done      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = blank;
    mem_raddr = cnt_q;
    col_n     = {1'b0, col_q};
    row_n     = {1'b0, row_q};

    case (state_q)
      StInit: begin
        mem_we    = 1'b1;
        mem_wdata = {ResetAttr, ChSpace};
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = StIdle;
        end
      end

      StIdle: begin
        mem_raddr = idx_w[AdrW-1:0];
        if (accept) begin
          case (mode_i)
            ModePut: begin
              case (char_code_i)
                ChNewline: begin
                  col_n = '0;
                  row_n = row_n + 1'b1;
                end
                ChBackspace: begin
                  if (col_q != '0) begin
                    col_n     = col_n - 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = row_base + AdrW'(col_q) - 1'b1;
                    mem_wdata = blank;
                  end
                end
                ChReturn: begin
                  col_n = '0;
                end
                default: begin
                  mem_we    = 1'b1;
                  mem_waddr = row_base + AdrW'(col_q);
                  mem_wdata = {attr, char_code_i};
                  col_n     = col_n + 1'b1;
                end
              endcase
              // wrap at the row end
              if (col_n >= (ColW + 1)'(COLUMNS)) begin
                col_n = '0;
                row_n = row_n + 1'b1;
              end
              col_d = col_n[ColW-1:0];
              // past the last row: scroll up
              if (row_n >= (RowW + 1)'(ROWS)) begin
                row_d   = RowW'(ROWS - 1);
                scr_d   = 1'b1;
                cnt_d   = Cols;
                state_d = StCopy;
              end else begin
                row_d  = row_n[RowW-1:0];
                val_d  = '0;
                oscr_d = 1'b0;
                done   = 1'b1;
              end
            end
            ModeClear: begin
              col_d   = '0;
              row_d   = '0;
              scr_d   = 1'b0;
              cnt_d   = '0;
              state_d = StFill;
            end
            ModeRead: begin
              rd_ok_d = (idx_w < WideW'(Cells));
              state_d = StRdWait;
            end
            default: begin
              val_d  = '0;
              oscr_d = 1'b0;
              done   = 1'b1;
            end
          endcase
        end
      end

      StRdWait: begin
        val_d   = rd_ok_q ? mem_rdata : '0;
        oscr_d  = 1'b0;
        done    = 1'b1;
        state_d = StIdle;
      end

      StCopy: begin
        // read one row ahead, write the cell read last cycle
        mem_raddr = cnt_q;
        mem_we    = cp_vld_q;
        mem_waddr = cp_dst_q;
        mem_wdata = mem_rdata;
        cp_vld_d  = 1'b1;
        cp_dst_d  = cnt_q - Cols;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LastCell) begin
          state_d = StDrain;
        end
      end

      StDrain: begin
        mem_we    = cp_vld_q;
        mem_waddr = cp_dst_q;
        mem_wdata = mem_rdata;
        cnt_d     = LastRow0;
        state_d   = StFill;
      end

      StFill: begin
        mem_we    = 1'b1;
        mem_wdata = blank;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          val_d   = '0;
          oscr_d  = scr_q;
          done    = 1'b1;
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // result register
  assign pos_w = WideW'(AdrW'(row_d) * Cols + AdrW'(col_d));
  always_comb begin
    out_vld_d = out_vld_q;
    pos_d     = pos_q;
    if (done) begin
      out_vld_d = 1'b1;
      pos_d     = pos_w[PosW-1:0];
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StInit;
      col_q     <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
      cp_vld_q  <= 1'b0;
      scr_q     <= 1'b0;
      rd_ok_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      cnt_q     <= cnt_d;
      cp_vld_q  <= cp_vld_d;
      scr_q     <= scr_d;
      rd_ok_q   <= rd_ok_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cp_dst_q <= cp_dst_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    oscr_q   <= oscr_d;
  end

  assign out_valid_o       = out_vld_q;
  assign cursor_position_o = pos_q;
  assign cell_value_o      = val_q;
  assign scrolled_o        = oscr_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StIdle) && (!out_vld_q || out_ready_i))
    else $error("input taken while busy or result pending");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < RowW'(ROWS - 1) || row_q == RowW'(ROWS - 1))
    else $error("cursor row out of range");

  a_read_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == ModeRead) |=> (state_q == StRdWait))
    else $error("read transaction did not wait for store data");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && oscr_q |-> (row_q == RowW'(ROWS - 1)))
    else $error("scroll reported with cursor off the last row");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCopy || state_q == StDrain) |-> !out_vld_q)
    else $error("result pending during scroll");
`endif

endmodule
